>>> rtl/iidl_pkg.sv
`default_nettype none
// ============================================================================
// iidl_pkg : shared types for the indexed insert/delete list
// Operation and status codes, sequencer states and the command/response words.
// ============================================================================
package iidl_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FUNC_W         = 3;
    localparam int IDX_W          = 6;
    localparam int WORD_W         = 32;
    localparam int CNT_W          = 6;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ       = 3'd0,
        FN_INSERT     = 3'd1,
        FN_REMOVE     = 3'd2,
        FN_PUSH_BACK  = 3'd3,
        FN_POP_BACK   = 3'd4,
        FN_PUSH_FRONT = 3'd5,
        FN_POP_FRONT  = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS,
        S_INS_LAST,
        S_INS_FIN,
        S_REM,
        S_REM_LAST
    } t_state;

    typedef struct packed {
        t_func                    func;
        logic [IDX_W-1:0]         index;
        logic signed [WORD_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        t_status                  status;
        logic [CNT_W-1:0]         element_count;
    } t_rsp;

endpackage
`default_nettype wire

>>> rtl/iidl_ram.sv
`default_nettype none
// ============================================================================
// iidl_ram : generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module iidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/indexed_insert_delete_list_core.sv
// ============================================================================
// indexed_insert_delete_list_core : bounded ordered list with indexed edits
// Errors, no-ops and appends answer on o_strobe in the cycle after the start;
// a read passes S_READ, a remove/pop S_REM and S_REM_LAST, an insert ahead of
// the tail S_INS, S_INS_LAST and S_INS_FIN. Entries move one per cycle through
// the single RAM write port; busy is high throughout and the next word waits.
// Synchronous active-low reset empties the list; entry contents stay as they are.
// ============================================================================
`default_nettype none
module indexed_insert_delete_list_core
    import iidl_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_cmd i_cmd,
    output logic      o_strobe,
    output t_rsp      o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > IDX_W) ? CW : IDX_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [AW-1:0]         r_prev, n_prev;
    logic [AW-1:0]         r_pos, n_pos;
    logic                  r_have, n_have;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [DATA_WIDTH-1:0] r_res, n_res;
    logic                  r_strobe, n_strobe;
    t_rsp                  r_rsp, n_rsp;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rd;

    logic [PW-1:0]         w_idx;
    logic [PW-1:0]         w_cnt;
    logic [PW-1:0]         w_ins_pos;
    logic [PW-1:0]         w_rem_pos;
    t_status               w_rem_err;

    iidl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign w_idx = PW'(i_cmd.index);
    assign w_cnt = PW'(r_count);

    always_comb begin
        unique case (i_cmd.func)
            FN_PUSH_BACK:  w_ins_pos = w_cnt;
            FN_PUSH_FRONT: w_ins_pos = '0;
            default:       w_ins_pos = w_idx;
        endcase
        unique case (i_cmd.func)
            FN_POP_BACK: begin
                w_rem_pos = w_cnt - PW'(1);
                w_rem_err = ST_EMPTY;
            end
            FN_POP_FRONT: begin
                w_rem_pos = '0;
                w_rem_err = ST_EMPTY;
            end
            default: begin
                w_rem_pos = w_idx;
                w_rem_err = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_prev <= n_prev;
        r_pos  <= n_pos;
        r_have <= n_have;
        r_val  <= n_val;
        r_res  <= n_res;
        r_rsp  <= n_rsp;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_prev   = r_prev;
        n_pos    = r_pos;
        n_have   = r_have;
        n_val    = r_val;
        n_res    = r_res;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        w_raddr  = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val    = DATA_WIDTH'(signed'(i_cmd.value));
                    n_have   = 1'b0;
                    n_strobe = 1'b1;
                    n_rsp.result_value  = '0;
                    n_rsp.status        = ST_OK;
                    n_rsp.element_count = CNT_W'(r_count);
                    unique case (i_cmd.func)
                        FN_READ: begin
                            if (w_idx < w_cnt) begin
                                w_raddr  = w_idx[AW-1:0];
                                n_strobe = 1'b0;
                                n_state  = S_READ;
                            end else begin
                                n_rsp.status = ST_RANGE;
                            end
                        end
                        FN_INSERT, FN_PUSH_BACK, FN_PUSH_FRONT: begin
                            if (w_ins_pos > w_cnt) begin
                                n_rsp.status = ST_RANGE;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_rsp.status = ST_FULL;
                            end else if (w_ins_pos == w_cnt) begin
                                // append at the tail: nothing to move
                                w_we    = 1'b1;
                                w_waddr = w_ins_pos[AW-1:0];
                                w_wdata = n_val;
                                n_count = r_count + CW'(1);
                                n_rsp.element_count = CNT_W'(n_count);
                            end else begin
                                n_ptr    = AW'(r_count - CW'(1));
                                n_pos    = w_ins_pos[AW-1:0];
                                n_strobe = 1'b0;
                                n_state  = S_INS;
                            end
                        end
                        FN_REMOVE, FN_POP_BACK, FN_POP_FRONT: begin
                            if (w_rem_pos >= w_cnt) begin
                                n_rsp.status = w_rem_err;
                            end else begin
                                n_ptr    = w_rem_pos[AW-1:0];
                                n_pos    = w_rem_pos[AW-1:0];
                                n_strobe = 1'b0;
                                n_state  = S_REM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_READ: begin
                n_strobe = 1'b1;
                n_rsp.result_value  = WORD_W'(signed'(w_rd));
                n_rsp.status        = ST_OK;
                n_rsp.element_count = CNT_W'(r_count);
                n_state  = S_IDLE;
            end

            // walk down from the tail, each word moving up by one
            S_INS: begin
                w_raddr = r_ptr;
                n_prev  = r_ptr;
                n_have  = 1'b1;
                n_ptr   = r_ptr - AW'(1);
                if (r_have) begin
                    w_we    = 1'b1;
                    w_waddr = r_prev + AW'(1);
                    w_wdata = w_rd;
                end
                if (r_ptr == r_pos) begin
                    n_state = S_INS_LAST;
                end
            end

            S_INS_LAST: begin
                w_we    = 1'b1;
                w_waddr = r_prev + AW'(1);
                w_wdata = w_rd;
                n_state = S_INS_FIN;
            end

            S_INS_FIN: begin
                w_we     = 1'b1;
                w_waddr  = r_pos;
                w_wdata  = r_val;
                n_count  = r_count + CW'(1);
                n_strobe = 1'b1;
                n_rsp.result_value  = '0;
                n_rsp.status        = ST_OK;
                n_rsp.element_count = CNT_W'(n_count);
                n_state  = S_IDLE;
            end

            // walk up from the removed slot; the first word read is the result
            S_REM: begin
                w_raddr = r_ptr;
                n_prev  = r_ptr;
                n_have  = 1'b1;
                n_ptr   = r_ptr + AW'(1);
                if (r_have) begin
                    if (r_prev == r_pos) begin
                        n_res = w_rd;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_prev - AW'(1);
                        w_wdata = w_rd;
                    end
                end
                if (CW'(r_ptr) == r_count - CW'(1)) begin
                    n_state = S_REM_LAST;
                end
            end

            S_REM_LAST: begin
                if (r_prev == r_pos) begin
                    n_rsp.result_value = WORD_W'(signed'(w_rd));
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_prev - AW'(1);
                    w_wdata = w_rd;
                    n_rsp.result_value = WORD_W'(signed'(r_res));
                end
                n_count  = r_count - CW'(1);
                n_strobe = 1'b1;
                n_rsp.status        = ST_OK;
                n_rsp.element_count = CNT_W'(n_count);
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

`ifndef NO_ASSERTIONS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word shown while the sequencer is busy");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond capacity");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CW'(w_waddr) <= r_count))
        else $error("RAM write beyond the list tail");

    a_start_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted word neither worked on nor answered");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb : testbench for indexed_insert_delete_list_core
// Issues list commands through the start/busy handshake and checks every
// strobed response, field by field and in order, against a behavioural list
// model kept in the bench. A short directed table comes first: the empty
// list, the word extremes, the index limits and the unused code. Random
// phases follow: balanced, fill-biased to reach the full list, drain-biased
// to hit the empty list, and a last balanced phase with back-to-back words.
// ============================================================================
module tb;
    import iidl_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam logic [FUNC_W-1:0] FN_NOOP = 3'd7;
    // covers the longest edit, which moves every entry, with margin to spare
    localparam int DRAIN_CYCLES = LIST_DEPTH + 10;

    typedef struct {
        logic [FUNC_W-1:0]        fn;
        logic [IDX_W-1:0]         idx;
        logic signed [WORD_W-1:0] val;
        bit                       typed;
        t_rsp                     rsp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_strobe;
    t_rsp o_rsp;

    indexed_insert_delete_list_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // bench copy of the list
    logic signed [WORD_W-1:0] list_mem [LIST_DEPTH];
    int list_len;

    t_rsp rsp_expected_q [$];
    t_dir_row dir_q [$];

    // word currently on offer, as seen by the checker
    logic [FUNC_W-1:0]        cur_fn;
    logic [IDX_W-1:0]         cur_idx;
    logic signed [WORD_W-1:0] cur_val;
    bit                       cur_typed;
    t_rsp                     cur_rsp;
    bit                       took;

    int n_fail;
    int n_reported;
    int n_items;
    int n_by_status [4];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic list_apply(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                              input logic signed [WORD_W-1:0] val, output t_rsp r);
        int pos;
        int i;
        bit ins;
        bit rem;
        t_status err;
        r.result_value = '0;
        r.status = ST_OK;
        ins = 1'b0;
        rem = 1'b0;
        err = ST_RANGE;
        pos = idx;
        case (fn)
            FN_READ: begin
                if (pos < list_len) r.result_value = list_mem[pos];
                else r.status = ST_RANGE;
            end
            FN_INSERT: ins = 1'b1;
            FN_REMOVE: rem = 1'b1;
            FN_PUSH_BACK: begin
                ins = 1'b1;
                pos = list_len;
            end
            FN_POP_BACK: begin
                rem = 1'b1;
                err = ST_EMPTY;
                pos = list_len - 1;
            end
            FN_PUSH_FRONT: begin
                ins = 1'b1;
                pos = 0;
            end
            FN_POP_FRONT: begin
                rem = 1'b1;
                err = ST_EMPTY;
                pos = 0;
            end
            default: ;
        endcase
        // index is checked before fullness
        if (ins) begin
            if (pos > list_len) begin
                r.status = ST_RANGE;
            end else if (list_len >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
                list_mem[pos] = val;
                list_len++;
            end
        end
        if (rem) begin
            if (pos < 0 || pos >= list_len) begin
                r.status = err;
            end else begin
                r.result_value = list_mem[pos];
                for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                list_len--;
            end
        end
        r.element_count = CNT_W'(list_len);
    endtask

    always @(posedge i_clk) begin : check_blk
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            took = 1'b0;
        end else begin
            if (o_strobe) begin
                got = o_rsp;
                if (rsp_expected_q.size() == 0) begin
                    n_fail++;
                    if (n_reported < 10)
                        $display("%0t: unexpected response: value %0d status %0d count %0d",
                                 $realtime, got.result_value, got.status, got.element_count);
                    n_reported++;
                end else begin
                    want = rsp_expected_q.pop_front();
                    if (got.result_value !== want.result_value || got.status !== want.status ||
                        got.element_count !== want.element_count) begin
                        n_fail++;
                        if (n_reported < 10)
                            $display("%0t: exp %0d/%0d/%0d got %0d/%0d/%0d (value/status/count)",
                                     $realtime, want.result_value, want.status,
                                     want.element_count, got.result_value, got.status,
                                     got.element_count);
                        n_reported++;
                    end
                end
            end
            took = start && !busy;
            if (took) begin
                list_apply(cur_fn, cur_idx, cur_val, want);
                n_items++;
                n_by_status[want.status]++;
                if (cur_typed) want = cur_rsp;
                rsp_expected_q.push_back(want);
            end
        end
    end

    task automatic add_row(input logic [FUNC_W-1:0] fn, input int idx,
                           input logic [WORD_W-1:0] val, input bit typed,
                           input logic [WORD_W-1:0] rv, input t_status st, input int cnt);
        t_dir_row row;
        row.fn = fn;
        row.idx = IDX_W'(idx);
        row.val = val;
        row.typed = typed;
        row.rsp.result_value = rv;
        row.rsp.status = st;
        row.rsp.element_count = CNT_W'(cnt);
        dir_q.push_back(row);
    endtask

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                             input logic signed [WORD_W-1:0] val, input bit typed,
                             input t_rsp rsp);
        cur_fn = fn;
        cur_idx = idx;
        cur_val = val;
        cur_typed = typed;
        cur_rsp = rsp;
        i_cmd <= t_cmd'({fn, idx, val});
        start <= 1'b1;
        do @(negedge i_clk); while (!took);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic pick_word(input int ph, output logic [FUNC_W-1:0] fn,
                             output logic [IDX_W-1:0] idx, output logic signed [WORD_W-1:0] val);
        int r;
        int ins_pct;
        int rem_pct;
        int hi;
        ins_pct = (ph == 1) ? 65 : (ph == 2) ? 15 : 35;
        rem_pct = (ph == 2) ? 65 : (ph == 1) ? 15 : 35;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            case ($urandom_range(0, 2))
                0: fn = FN_INSERT;
                1: fn = FN_PUSH_BACK;
                default: fn = FN_PUSH_FRONT;
            endcase
        end else if (r < ins_pct + rem_pct) begin
            case ($urandom_range(0, 2))
                0: fn = FN_REMOVE;
                1: fn = FN_POP_BACK;
                default: fn = FN_POP_FRONT;
            endcase
        end else if (r < 97) begin
            fn = FN_READ;
        end else begin
            fn = FN_NOOP;
        end
        // mostly in range; the rest anywhere up to the capacity
        if ($urandom_range(0, 9) < 8) begin
            hi = (fn == FN_INSERT) ? list_len : ((list_len > 0) ? list_len - 1 : 0);
            idx = IDX_W'($urandom_range(0, hi));
        end else begin
            idx = IDX_W'($urandom_range(0, LIST_DEPTH));
        end
        case ($urandom_range(0, 7))
            0: val = 32'sh8000_0000;
            1: val = 32'sh7fff_ffff;
            2: val = '0;
            3: val = -32'sd1;
            4: val = $signed($urandom_range(0, 255)) - 32'sd128;
            default: val = $urandom;
        endcase
    endtask

    initial begin : stim_blk
        logic [FUNC_W-1:0]        fn;
        logic [IDX_W-1:0]         idx;
        logic signed [WORD_W-1:0] val;
        t_rsp none;
        int k;
        int ph;
        int phase_len [4];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        took = 1'b0;
        list_len = 0;
        n_fail = 0;
        n_reported = 0;
        n_items = 0;
        for (k = 0; k < 4; k++) n_by_status[k] = 0;
        none = '0;
        phase_len[0] = 500;
        phase_len[1] = 450;
        phase_len[2] = 450;
        phase_len[3] = 480;

        add_row(FN_READ,       0, 32'h0,         1, 32'h0,         ST_RANGE, 0);
        add_row(FN_POP_BACK,   0, 32'h0,         1, 32'h0,         ST_EMPTY, 0);
        add_row(FN_POP_FRONT,  0, 32'h0,         1, 32'h0,         ST_EMPTY, 0);
        add_row(FN_REMOVE,     0, 32'h0,         1, 32'h0,         ST_RANGE, 0);
        add_row(FN_INSERT,     1, 32'h5,         1, 32'h0,         ST_RANGE, 0);
        add_row(FN_NOOP,       0, 32'hffff_ffff, 1, 32'h0,         ST_OK,    0);
        add_row(FN_PUSH_BACK,  0, 32'h7fff_ffff, 1, 32'h0,         ST_OK,    1);
        add_row(FN_PUSH_FRONT, 0, 32'h8000_0000, 1, 32'h0,         ST_OK,    2);
        add_row(FN_READ,       0, 32'h0,         1, 32'h8000_0000, ST_OK,    2);
        add_row(FN_READ,       1, 32'h0,         1, 32'h7fff_ffff, ST_OK,    2);
        add_row(FN_READ,       2, 32'h0,         1, 32'h0,         ST_RANGE, 2);
        add_row(FN_INSERT,     3, 32'h1,         1, 32'h0,         ST_RANGE, 2);
        add_row(FN_INSERT,     1, 32'hffff_ffff, 1, 32'h0,         ST_OK,    3);
        add_row(FN_INSERT,     3, 32'h0,         1, 32'h0,         ST_OK,    4);
        add_row(FN_READ,      32, 32'h0,         1, 32'h0,         ST_RANGE, 4);
        add_row(FN_INSERT,    32, 32'h2,         1, 32'h0,         ST_RANGE, 4);
        add_row(FN_REMOVE,     1, 32'h0,         1, 32'hffff_ffff, ST_OK,    3);
        add_row(FN_NOOP,      32, 32'h0,         1, 32'h0,         ST_OK,    3);
        add_row(FN_POP_BACK,   0, 32'h0,         1, 32'h0,         ST_OK,    2);
        add_row(FN_POP_FRONT,  0, 32'h0,         1, 32'h8000_0000, ST_OK,    1);
        add_row(FN_REMOVE,     4, 32'h0,         1, 32'h0,         ST_RANGE, 1);
        add_row(FN_REMOVE,     0, 32'h0,         1, 32'h7fff_ffff, ST_OK,    0);
        add_row(FN_INSERT,     0, 32'h1234_5678, 0, 32'h0,         ST_OK,    0);
        add_row(FN_PUSH_FRONT, 0, 32'hedcb_a987, 0, 32'h0,         ST_OK,    0);
        add_row(FN_READ,       1, 32'h0,         0, 32'h0,         ST_OK,    0);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < dir_q.size(); k++) begin
            if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 10));
            send_word(dir_q[k].fn, dir_q[k].idx, dir_q[k].val, dir_q[k].typed, dir_q[k].rsp);
        end

        // balanced, fill-biased, drain-biased, then balanced with no gaps
        for (ph = 0; ph < 4; ph++) begin
            for (k = 0; k < phase_len[ph]; k++) begin
                if (ph < 3 && $urandom_range(0, 9) < 3) hold_off($urandom_range(1, 10));
                pick_word(ph, fn, idx, val);
                send_word(fn, idx, val, 1'b0, none);
            end
        end
        start <= 1'b0;

        while (rsp_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        n_fail += rsp_expected_q.size();

        $display("Directed edge rows, then balanced, fill, drain and gap-free random phases.");
        $display("Ran %0d words: %0d ok, %0d bad index, %0d empty, %0d full, %0d failures",
                 n_items, n_by_status[ST_OK], n_by_status[ST_RANGE], n_by_status[ST_EMPTY],
                 n_by_status[ST_FULL], n_fail);
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
